[rtl/core/lkvt_pkg.sv]
// ----------------------------------------------------------------------------
// lkvt_pkg
// shared types and constants of the linear key/value table unit
// ----------------------------------------------------------------------------
`default_nettype none

package lkvt_pkg;

  // command field
  localparam int unsigned CMD_W = 3;
  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_INSERT   = 3'd0;
  localparam cmd_t CMD_UPDATE   = 3'd1;
  localparam cmd_t CMD_UPSERT   = 3'd2;
  localparam cmd_t CMD_ERASE    = 3'd3;
  localparam cmd_t CMD_CONTAINS = 3'd4;
  localparam cmd_t CMD_GET_KEY  = 3'd5;
  localparam cmd_t CMD_GET_POS  = 3'd6;

  // fixed field widths of the command and result beats
  localparam int unsigned POS_W   = 6;
  localparam int unsigned COUNT_W = 7;

endpackage

`default_nettype wire

[rtl/core/lkvt_ram.sv]
// ----------------------------------------------------------------------------
// lkvt_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lkvt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/core/linear_key_value_table_unit.sv]
// ----------------------------------------------------------------------------
// linear_key_value_table_unit
// fixed-capacity key/value table in insertion order, searched linearly
// ----------------------------------------------------------------------------
// a lookup scans one entry per cycle; erase adds one move per later entry
// get_by_position reads in an address phase, then a data phase; an unused
// command code answers straight from the idle state
// the single ram read port sets the pace; one command at a time, busy_o high
// result beat is a one-cycle done_o pulse, the receiver cannot stall it
// reset empties the table at once (count to zero), no clearing pass
`default_nettype none

module linear_key_value_table_unit #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // command beat
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic [lkvt_pkg::CMD_W-1:0] command_i,
  input  wire logic [KEY_WIDTH-1:0]       key_i,
  input  wire logic [VALUE_WIDTH-1:0]     value_in_i,
  input  wire logic [lkvt_pkg::POS_W-1:0] position_i,
  // result beat
  output logic                            done_o,
  output logic                            ok_o,
  output logic [KEY_WIDTH-1:0]            key_out_o,
  output logic [VALUE_WIDTH-1:0]          value_out_o,
  output logic [lkvt_pkg::COUNT_W-1:0]    entry_count_o,
  output logic                            is_empty_o
);

  import lkvt_pkg::*;

  // address, count and compare widths
  localparam int unsigned AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned PW  = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned OW  = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int unsigned EW  = KEY_WIDTH + VALUE_WIDTH;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;  // linear search, one read per cycle
  localparam logic [2:0] ST_ACT    = 3'd2;  // apply the command to the scan outcome
  localparam logic [2:0] ST_MOVE   = 3'd3;  // erase compaction, entry j+1 to j
  localparam logic [2:0] ST_POS_RD = 3'd4;  // read by position, address phase
  localparam logic [2:0] ST_POS_CP = 3'd5;  // read by position, data phase

  logic [2:0]             state_q, state_d;
  logic [CW-1:0]          count_q, count_d;   // valid entries 0 .. count-1
  logic [CW-1:0]          idx_q, idx_d;       // next entry to read
  logic                   rd_vld_q, rd_vld_d; // a read is in flight
  logic [AW-1:0]          rd_idx_q, rd_idx_d; // address of that read
  logic                   found_q, found_d;
  logic [AW-1:0]          slot_q, slot_d;
  logic                   done_q, done_d;

  // latched command beat
  cmd_t                   cmd_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [POS_W-1:0]       pos_q;

  // result payload and value captured on a hit
  logic                   ok_q, ok_d;
  logic [KEY_WIDTH-1:0]   kout_q, kout_d;
  logic [VALUE_WIDTH-1:0] vout_q, vout_d;
  logic [VALUE_WIDTH-1:0] vcap_q, vcap_d;

  // ram port
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [EW-1:0]          ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [EW-1:0]          ram_rdata;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;

  logic                   accept;
  logic [PW-1:0]          pos_ext;
  logic [OW-1:0]          count_ext;

  assign accept    = start_i && !busy_o;
  assign rd_key    = ram_rdata[EW-1:VALUE_WIDTH];
  assign rd_val    = ram_rdata[VALUE_WIDTH-1:0];
  assign pos_ext   = PW'(pos_q);
  assign count_ext = OW'(count_q);

  // entries live as {key, value} words in one memory
  lkvt_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    rd_vld_d  = 1'b0;
    rd_idx_d  = rd_idx_q;
    found_d   = found_q;
    slot_d    = slot_q;
    done_d    = 1'b0;
    ok_d      = ok_q;
    kout_d    = kout_q;
    vout_d    = vout_q;
    vcap_d    = vcap_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d   = '0;
          found_d = 1'b0;
          ok_d    = 1'b0;
          kout_d  = '0;
          vout_d  = '0;
          unique case (command_i) inside
            CMD_INSERT, CMD_UPDATE, CMD_UPSERT,
            CMD_ERASE, CMD_CONTAINS, CMD_GET_KEY: state_d = ST_SCAN;
            CMD_GET_POS:                          state_d = ST_POS_RD;
            default:                              done_d  = 1'b1;  // unused code: no-op
          endcase
        end
      end

      ST_SCAN: begin
        // reads are pipelined: issue one address while comparing the last
        if (rd_vld_q && rd_key == key_q) begin
          found_d = 1'b1;
          slot_d  = rd_idx_q;
          vcap_d  = rd_val;
          state_d = ST_ACT;
        end else if (idx_q < count_q) begin
          ram_raddr = idx_q[AW-1:0];
          rd_vld_d  = 1'b1;
          rd_idx_d  = idx_q[AW-1:0];
          idx_d     = idx_q + CW'(1);
        end else if (!rd_vld_q) begin
          state_d = ST_ACT;  // end of table, key absent
        end
      end

      ST_ACT: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        unique case (cmd_q) inside
          CMD_INSERT, CMD_UPDATE, CMD_UPSERT: begin
            if (found_q && cmd_q != CMD_INSERT) begin
              ram_we    = 1'b1;
              ram_waddr = slot_q;
              ram_wdata = {key_q, val_q};
              ok_d      = 1'b1;
            end else if (!found_q && cmd_q != CMD_UPDATE && count_q < CW'(CAPACITY)) begin
              // append at the tail
              ram_we    = 1'b1;
              ram_waddr = count_q[AW-1:0];
              ram_wdata = {key_q, val_q};
              count_d   = count_q + CW'(1);
              ok_d      = 1'b1;
            end
          end
          CMD_ERASE: begin
            if (found_q) begin
              ok_d    = 1'b1;
              idx_d   = CW'(slot_q) + CW'(1);
              state_d = ST_MOVE;
              done_d  = 1'b0;
            end
          end
          CMD_CONTAINS: begin
            ok_d = found_q;
          end
          CMD_GET_KEY: begin
            if (found_q) begin
              ok_d   = 1'b1;
              vout_d = vcap_q;
            end
          end
          default: begin
          end
        endcase
      end

      ST_MOVE: begin
        // write back the entry read in the previous cycle, one slot lower
        if (rd_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_q - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (idx_q < count_q) begin
          ram_raddr = idx_q[AW-1:0];
          rd_vld_d  = 1'b1;
          rd_idx_d  = idx_q[AW-1:0];
          idx_d     = idx_q + CW'(1);
        end else if (!rd_vld_q) begin
          count_d = count_q - CW'(1);
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end

      ST_POS_RD: begin
        if (pos_ext < PW'(count_q)) begin
          ram_raddr = pos_ext[AW-1:0];
          state_d   = ST_POS_CP;
        end else begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end

      ST_POS_CP: begin
        ok_d    = 1'b1;
        kout_d  = rd_key;
        vout_d  = rd_val;
        state_d = ST_IDLE;
        done_d  = 1'b1;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_vld_d;
      found_q  <= found_d;
      done_q   <= done_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      key_q <= key_i;
      val_q <= value_in_i;
      pos_q <= position_i;
    end
    rd_idx_q <= rd_idx_d;
    slot_q   <= slot_d;
    ok_q     <= ok_d;
    kout_q   <= kout_d;
    vout_q   <= vout_d;
    vcap_q   <= vcap_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign ok_o          = ok_q;
  assign key_out_o     = kout_q;
  assign value_out_o   = vout_q;
  assign entry_count_o = count_ext[COUNT_W-1:0];
  assign is_empty_o    = (count_q == '0);

  // count stays within capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // a failed command reports zero key and value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !ok_o |-> key_out_o == '0 && value_out_o == '0)
    else $error("failed command reports data");

  // count changes only together with a result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> done_o)
    else $error("count changed outside a finishing cycle");

  // ram is written only while a command is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> busy_o)
    else $error("memory write while idle");

  // a read by position never goes past the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_POS_CP |-> pos_ext < PW'(count_q))
    else $error("position read beyond count");

endmodule

`default_nettype wire

[sim/linear_key_value_table_unit_checker.sv]
// ----------------------------------------------------------------------------
// linear_key_value_table_unit_checker
// watches the command and result beats, keeps a shadow of the table and
// compares every result beat field by field with the predicted one
// ----------------------------------------------------------------------------
`default_nettype none

module linear_key_value_table_unit_checker #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic                           busy_i,
  input  wire logic [lkvt_pkg::CMD_W-1:0]     command_i,
  input  wire logic [KEY_WIDTH-1:0]           key_i,
  input  wire logic [VALUE_WIDTH-1:0]         value_in_i,
  input  wire logic [lkvt_pkg::POS_W-1:0]     position_i,
  input  wire logic                           done_i,
  input  wire logic                           ok_i,
  input  wire logic [KEY_WIDTH-1:0]           key_out_i,
  input  wire logic [VALUE_WIDTH-1:0]         value_out_i,
  input  wire logic [lkvt_pkg::COUNT_W-1:0]   entry_count_i,
  input  wire logic                           is_empty_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);

  import lkvt_pkg::*;

  typedef struct packed {
    logic                   ok;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
    logic [COUNT_W-1:0]     count;
    logic                   empty;
  } answer_t;

  // shadow table, oldest entry first
  logic [KEY_WIDTH-1:0]   held_keys   [CAPACITY];
  logic [VALUE_WIDTH-1:0] held_values [CAPACITY];
  int unsigned            held_count;

  answer_t awaited_answers [$];

  function automatic answer_t run_table_command(input cmd_t op,
                                                input logic [KEY_WIDTH-1:0] k,
                                                input logic [VALUE_WIDTH-1:0] v,
                                                input logic [POS_W-1:0] p);
    answer_t     ans;
    int unsigned slot;
    int unsigned i;
    bit          hit;
    ans  = '0;
    slot = held_count;
    // keys are unique, so the last match is the only match
    for (i = 0; i < held_count; i++) begin
      if (held_keys[i] == k) slot = i;
    end
    hit = (slot < held_count);
    case (op) inside
      CMD_INSERT, CMD_UPDATE, CMD_UPSERT: begin
        if (hit && op != CMD_INSERT) begin
          held_values[slot] = v;
          ans.ok = 1'b1;
        end else if (!hit && op != CMD_UPDATE && held_count < CAPACITY) begin
          held_keys[held_count]   = k;
          held_values[held_count] = v;
          held_count++;
          ans.ok = 1'b1;
        end
      end
      CMD_ERASE: begin
        if (hit) begin
          // close the gap, later entries move down by one
          for (i = slot; i + 1 < held_count; i++) begin
            held_keys[i]   = held_keys[i + 1];
            held_values[i] = held_values[i + 1];
          end
          held_count--;
          ans.ok = 1'b1;
        end
      end
      CMD_CONTAINS: begin
        ans.ok = hit;
      end
      CMD_GET_KEY: begin
        if (hit) begin
          ans.value = held_values[slot];
          ans.ok    = 1'b1;
        end
      end
      CMD_GET_POS: begin
        if (p < held_count) begin
          ans.key   = held_keys[p];
          ans.value = held_values[p];
          ans.ok    = 1'b1;
        end
      end
      default: begin
      end
    endcase
    ans.count = COUNT_W'(held_count);
    ans.empty = (held_count == 0);
    return ans;
  endfunction

  task automatic compare_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      held_count   = 0;
      fail_count_o = 0;
      pending_o    = 0;
      awaited_answers.delete();
    end else begin
      // result first: a new command may be taken on the edge that ends a result
      if (done_i) begin
        if (awaited_answers.size() == 0) begin
          $display("%0t: result beat with no command outstanding", $time);
          fail_count_o++;
        end else begin
          want = awaited_answers.pop_front();
          compare_field("ok", 64'(want.ok), 64'(ok_i));
          compare_field("key_out", 64'(want.key), 64'(key_out_i));
          compare_field("value_out", 64'(want.value), 64'(value_out_i));
          compare_field("entry_count", 64'(want.count), 64'(entry_count_i));
          compare_field("is_empty", 64'(want.empty), 64'(is_empty_i));
        end
      end
      if (start_i && !busy_i) begin
        awaited_answers.push_back(run_table_command(cmd_t'(command_i), key_i,
                                                    value_in_i, position_i));
      end
      pending_o = awaited_answers.size();
    end
  end

endmodule

`default_nettype wire

[sim/linear_key_value_table_unit_tb.sv]
// ----------------------------------------------------------------------------
// linear_key_value_table_unit_tb
// drives command beats into the table unit, a checker beside it predicts and
// compares every result beat; directed corner cases, then random traffic
// ----------------------------------------------------------------------------
`default_nettype none

module linear_key_value_table_unit_tb;
  import lkvt_pkg::*;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned KEY_WIDTH   = 32;
  localparam int unsigned VALUE_WIDTH = 32;

  // code 7 has no operation behind it, the unit must answer ok = 0
  localparam cmd_t CMD_UNUSED = 3'd7;

  localparam int RANDOM_ITEMS = 1600;
  // no idling in the last stretch of the run
  localparam int QUIET_TAIL   = 200;
  // drain wait; the worst beat is an erase in a full table
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;
  // cycles without any beat before the run is declared hung
  localparam int STALL_LIMIT  = 2000;
  localparam int POOL_SIZE    = 96;

  // traffic mixes, each leans on a different part of the table's life
  typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN, MIX_READ} mix_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic [CMD_W-1:0]       command_i;
  logic [KEY_WIDTH-1:0]   key_i;
  logic [VALUE_WIDTH-1:0] value_in_i;
  logic [POS_W-1:0]       position_i;
  logic                   done_o;
  logic                   ok_o;
  logic [KEY_WIDTH-1:0]   key_out_o;
  logic [VALUE_WIDTH-1:0] value_out_o;
  logic [COUNT_W-1:0]     entry_count_o;
  logic                   is_empty_o;

  int fail_count;
  int pending;
  int stall_cycles;
  bit idle_on;

  // keys drawn from a small pool so that hits, duplicates and a full table
  // actually happen; pool size above capacity so inserts can also overflow
  logic [KEY_WIDTH-1:0] key_pool [POOL_SIZE];

  always #1 clk_i = ~clk_i;

  linear_key_value_table_unit #(
    .CAPACITY   (CAPACITY),
    .KEY_WIDTH  (KEY_WIDTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .command_i    (command_i),
    .key_i        (key_i),
    .value_in_i   (value_in_i),
    .position_i   (position_i),
    .done_o       (done_o),
    .ok_o         (ok_o),
    .key_out_o    (key_out_o),
    .value_out_o  (value_out_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o)
  );

  linear_key_value_table_unit_checker #(
    .CAPACITY   (CAPACITY),
    .KEY_WIDTH  (KEY_WIDTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .command_i    (command_i),
    .key_i        (key_i),
    .value_in_i   (value_in_i),
    .position_i   (position_i),
    .done_i       (done_o),
    .ok_i         (ok_o),
    .key_out_i    (key_out_o),
    .value_out_i  (value_out_o),
    .entry_count_i(entry_count_o),
    .is_empty_i   (is_empty_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // hang detection: any accepted beat, command or result, resets the count
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one command beat; an optional idle burst first, then hold start until
  // busy is seen low ahead of an edge, busy is stable at the falling edge
  task automatic send_cmd(input cmd_t op, input logic [KEY_WIDTH-1:0] k,
                          input logic [VALUE_WIDTH-1:0] v,
                          input logic [POS_W-1:0] p);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    command_i  <= op;
    key_i      <= k;
    value_in_i <= v;
    position_i <= p;
    do @(negedge clk_i); while (busy_o !== 1'b0);
    @(posedge clk_i);
  endtask

  // mostly pool keys, some fully random ones that rarely hit
  function automatic logic [KEY_WIDTH-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // low positions hit even in a sparse table, the full range covers the rest
  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 1) == 0) return POS_W'($urandom_range(0, 7));
    return POS_W'($urandom_range(0, 63));
  endfunction

  // cumulative percentages in command code order, insert through
  // get_by_position; whatever is left over goes to the unused code
  function automatic cmd_t pick_command(input mix_t mix);
    int   cut [7];
    int   r;
    int   i;
    cmd_t op;
    case (mix)
      MIX_FILL:  cut = '{45, 70, 78, 83, 88, 93, 98};
      MIX_CHURN: cut = '{20, 35, 47, 67, 77, 87, 98};
      MIX_DRAIN: cut = '{5, 10, 18, 73, 81, 89, 98};
      default:   cut = '{5, 10, 20, 25, 45, 70, 98};
    endcase
    op = CMD_UNUSED;
    r  = $urandom_range(0, 99);
    for (i = 6; i >= 0; i--) begin
      if (r < cut[i]) op = cmd_t'(i);
    end
    return op;
  endfunction

  initial begin
    int   items_left;
    int   block_len;
    mix_t mix;

    rst_ni     <= 1'b0;
    start_i    <= 1'b0;
    command_i  <= CMD_CONTAINS;
    key_i      <= '0;
    value_in_i <= '0;
    position_i <= '0;
    idle_on    = 1'b1;

    foreach (key_pool[n]) key_pool[n] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: every lookup and change must miss
    send_cmd(CMD_CONTAINS, '0, '0, '0);
    send_cmd(CMD_ERASE, '0, '0, '0);
    send_cmd(CMD_UPDATE, '0, 32'h1111_1111, '0);
    send_cmd(CMD_GET_KEY, '0, '0, '0);
    send_cmd(CMD_GET_POS, '1, '1, '0);

    // extreme keys and values, then a duplicate insert that must fail
    send_cmd(CMD_INSERT, '0, '1, '0);
    send_cmd(CMD_INSERT, '1, '0, '1);
    send_cmd(CMD_INSERT, '0, 32'h2222_2222, '0);
    send_cmd(CMD_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A, '0);

    // update in place, upsert as update, upsert as insert
    send_cmd(CMD_UPDATE, '0, 32'h1234_5678, '0);
    send_cmd(CMD_UPSERT, '1, 32'h0000_0001, '0);
    send_cmd(CMD_UPSERT, 32'h0F0F_0F0F, 32'hF0F0_F0F0, '0);
    send_cmd(CMD_GET_KEY, '1, '0, '0);

    // reads by position: past the end, then the last entry
    send_cmd(CMD_GET_POS, '1, '1, '1);
    send_cmd(CMD_GET_POS, '0, '0, 6'd3);

    // unused code with busy fields, must change nothing
    send_cmd(CMD_UNUSED, 32'hA5A5_A5A5, '1, 6'd2);

    // erase from the middle, check the later entries moved down
    send_cmd(CMD_ERASE, '1, '0, '0);
    send_cmd(CMD_GET_POS, '0, '0, 6'd1);
    send_cmd(CMD_GET_POS, '0, '0, 6'd2);

    // erase the last, the first, then the only entry left
    send_cmd(CMD_ERASE, 32'h0F0F_0F0F, '0, '0);
    send_cmd(CMD_ERASE, '0, '0, '0);
    send_cmd(CMD_ERASE, 32'hA5A5_A5A5, '0, '0);
    send_cmd(CMD_CONTAINS, 32'hA5A5_A5A5, '0, '0);

    // random traffic in blocks; the first block uses the fill mix to push the table to capacity
    items_left = RANDOM_ITEMS;
    mix        = MIX_FILL;
    block_len  = 250;
    while (items_left > 0) begin
      idle_on = (items_left > QUIET_TAIL);
      send_cmd(pick_command(mix), pick_key(), pick_value(), pick_position());
      items_left--;
      block_len--;
      if (block_len == 0) begin
        mix       = mix_t'($urandom_range(0, 3));
        block_len = $urandom_range(80, 250);
      end
    end
    start_i <= 1'b0;

    // wait for the last result beat, then let the unit settle
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/core/lkvt_pkg.sv
rtl/core/lkvt_ram.sv
rtl/core/linear_key_value_table_unit.sv
sim/linear_key_value_table_unit_checker.sv
sim/linear_key_value_table_unit_tb.sv
